// File: rtl/ttblh_pkg.sv
// Package for the tick timer block: item types, register indexes, reset values.
// No dependencies; every other file takes what it needs from here.
package ttblh_pkg;

	localparam int unsigned TIMER_WIDTH = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned COUNT_W     = 8;

	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd200;
	localparam logic [PERIOD_W-1:0] HOLD_TIME_RST     = 16'd200;
	localparam logic [PERIOD_W-1:0] LIT_TICKS_RST     = 16'd1500;
	localparam logic [PERIOD_W-1:0] HAPTIC_HALF_RST   = 16'd300;
	localparam logic [COUNT_W-1:0]  PULSE_TOTAL_RST   = 8'd5;
	localparam logic [COUNT_W-1:0]  PULSE_COUNT_MAX   = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_PERIOD = 3'd0,
		CFG_HOLD_TIME     = 3'd1,
		CFG_LIT_TICKS     = 3'd2,
		CFG_HAPTIC_HALF   = 3'd3,
		CFG_PULSE_TOTAL   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic button_pressed;
		logic haptic_start;
	} in_item_t;

	typedef struct packed {
		logic sample_due;
		logic button_active;
		logic haptic_due;
		logic led_level;
		logic motor_level;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_item_t;

endpackage

// File: rtl/ttblh_if.sv
// Handshake channel interfaces: tick input, result output, register writes.
// Depends on ttblh_pkg for the payload types.
interface ttblh_in_if;
	logic                valid;
	logic                ready;
	ttblh_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ttblh_out_if;
	logic                 valid;
	logic                 ready;
	ttblh_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ttblh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ttblh_pkg::CFG_IDX_W-1:0]  index;
	logic [ttblh_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ttblh_core.sv
// Timer state, configuration registers and the per-tick update logic.
// Depends on ttblh_pkg; driven by the top level with one item per advance.
module ttblh_core #(
	parameter int unsigned TIMER_WIDTH = ttblh_pkg::TIMER_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ttblh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttblh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              advance,
	input  ttblh_pkg::in_item_t               item,
	output ttblh_pkg::out_item_t              result
);

	localparam int unsigned TW = TIMER_WIDTH;
	localparam int unsigned PW = ttblh_pkg::PERIOD_W;
	localparam int unsigned CW = ttblh_pkg::COUNT_W;

	logic [PW-1:0] sample_period_q, hold_time_q, lit_ticks_q, haptic_half_q;
	logic [CW-1:0] pulse_total_q;

	logic [TW-1:0] sample_left_q, button_left_q, haptic_left_q;
	logic          button_was_q, button_engaged_q, button_expired_prev_q;
	logic          led_state_q, haptic_engaged_q, motor_state_q;
	logic [CW-1:0] pulse_count_q;

	logic [TW-1:0] sample_left_d, button_left_d, haptic_left_d;
	logic          button_engaged_d, led_state_d, haptic_engaged_d, motor_state_d;
	logic [CW-1:0] pulse_count_d;
	logic          sdue, bexp, hdue;

	function automatic logic [TW-1:0] reload_of(input logic [PW-1:0] p);
		reload_of = (p == '0) ? '0 : TW'(p - PW'(1));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= ttblh_pkg::SAMPLE_PERIOD_RST;
			hold_time_q     <= ttblh_pkg::HOLD_TIME_RST;
			lit_ticks_q     <= ttblh_pkg::LIT_TICKS_RST;
			haptic_half_q   <= ttblh_pkg::HAPTIC_HALF_RST;
			pulse_total_q   <= ttblh_pkg::PULSE_TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttblh_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
				ttblh_pkg::CFG_HOLD_TIME:     hold_time_q     <= cfg_data;
				ttblh_pkg::CFG_LIT_TICKS:     lit_ticks_q     <= cfg_data;
				ttblh_pkg::CFG_HAPTIC_HALF:   haptic_half_q   <= cfg_data;
				ttblh_pkg::CFG_PULSE_TOTAL:   pulse_total_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		button_left_d    = button_left_q;
		button_engaged_d = button_engaged_q;
		led_state_d      = led_state_q;
		haptic_left_d    = haptic_left_q;
		haptic_engaged_d = haptic_engaged_q;
		pulse_count_d    = pulse_count_q;
		motor_state_d    = motor_state_q;

		// press edge starts the hold timer
		if (!button_was_q && item.button_pressed) begin
			button_left_d    = TW'(hold_time_q);
			button_engaged_d = 1'b1;
		end
		if (!button_expired_prev_q && !item.button_pressed && !led_state_q)
			button_engaged_d = 1'b0;

		if (item.haptic_start) begin
			haptic_left_d    = '0;
			haptic_engaged_d = 1'b1;
			pulse_count_d    = '0;
			motor_state_d    = 1'b0;
		end

		sdue = (sample_left_q == '0);
		sample_left_d = sdue ? reload_of(sample_period_q) : sample_left_q - TW'(1);

		bexp = button_engaged_d && (button_left_d == '0);
		if (bexp) begin
			if (led_state_q) begin
				led_state_d      = 1'b0;
				button_engaged_d = 1'b0;
			end else begin
				led_state_d   = 1'b1;
				button_left_d = reload_of(lit_ticks_q);
			end
		end else if (button_engaged_d) begin
			button_left_d = button_left_d - TW'(1);
		end

		hdue = haptic_engaged_d && (haptic_left_d == '0);
		if (hdue) begin
			haptic_left_d = reload_of(haptic_half_q);
			motor_state_d = !motor_state_d;
			if (motor_state_d) begin
				if (pulse_count_d != ttblh_pkg::PULSE_COUNT_MAX)
					pulse_count_d = pulse_count_d + CW'(1);
			end else if (pulse_count_d >= pulse_total_q) begin
				haptic_engaged_d = 1'b0;
			end
		end else if (haptic_engaged_d) begin
			haptic_left_d = haptic_left_d - TW'(1);
		end

		result.sample_due    = sdue;
		result.button_active = button_engaged_d;
		result.haptic_due    = hdue;
		result.led_level     = led_state_d;
		result.motor_level   = motor_state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_left_q         <= '0;
			button_left_q         <= '0;
			haptic_left_q         <= '0;
			button_was_q          <= 1'b0;
			button_engaged_q      <= 1'b0;
			button_expired_prev_q <= 1'b0;
			led_state_q           <= 1'b0;
			haptic_engaged_q      <= 1'b0;
			motor_state_q         <= 1'b0;
			pulse_count_q         <= '0;
		end else if (advance) begin
			sample_left_q         <= sample_left_d;
			button_left_q         <= button_left_d;
			haptic_left_q         <= haptic_left_d;
			button_was_q          <= item.button_pressed;
			button_engaged_q      <= button_engaged_d;
			button_expired_prev_q <= bexp;
			led_state_q           <= led_state_d;
			haptic_engaged_q      <= haptic_engaged_d;
			motor_state_q         <= motor_state_d;
			pulse_count_q         <= pulse_count_d;
		end
	end

endmodule

// File: rtl/ttblh_out_buf.sv
// Result register with one skid entry, so the core keeps running one stall deep.
// Depends on ttblh_pkg for the result type.
module ttblh_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ttblh_pkg::out_item_t push_data,
	output logic                 can_take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ttblh_pkg::out_item_t out_data
);

	logic                 main_valid_q, skid_valid_q;
	ttblh_pkg::out_item_t main_q, skid_q;
	logic                 pop;

	assign pop       = main_valid_q && out_ready;
	assign can_take  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// File: rtl/tick_timers_button_led_haptic_top.sv
// Millisecond tick timers: sampling pulse, button-hold LED and haptic pulse train.
// Usage:
//   tick_in    one item per millisecond tick (button level, haptic start strobe).
//   result_out one item per tick: sample_due, button_active, haptic_due,
//              led_level, motor_level.
//   cfg        register writes (index 0..4, others ignored); always ready.
//              Write only while no tick is in flight.
// Path: an accepted tick lands in the input register; the core updates its state
// from it and writes the result to the result register (or to the skid entry).
// Throughput: one tick per cycle while the skid entry is free, set by the single
// state-update pass between the input register and the result register.
// Receiver stall: the result register plus one skid entry absorb the stall;
// tick_in.ready drops only when both hold results and the input register
// is full. No item is dropped.
// Reset: all timers zero (sampling due on the first tick), LED and motor off,
// registers back to their defaults; no clearing pass.
// Depends on ttblh_pkg, ttblh_if, ttblh_core, ttblh_out_buf.
module tick_timers_button_led_haptic_top #(
	parameter int unsigned TIMER_WIDTH = ttblh_pkg::TIMER_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	ttblh_in_if.sink     tick_in,
	ttblh_out_if.source  result_out,
	ttblh_cfg_if.sink    cfg
);

	logic                 valid_s1;
	ttblh_pkg::in_item_t  item_s1;
	logic                 advance, can_take;
	ttblh_pkg::out_item_t result;

	assign advance       = valid_s1 && can_take;
	assign tick_in.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.ready) begin
			valid_s1 <= tick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.ready && tick_in.valid)
			item_s1 <= tick_in.data;
	end

	ttblh_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data (cfg.data),
		.advance  (advance),
		.item     (item_s1),
		.result   (result)
	);

	ttblh_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.push_data(result),
		.can_take (can_take),
		.out_valid(result_out.valid),
		.out_ready(result_out.ready),
		.out_data (result_out.data)
	);

endmodule

// File: rtl/ttblh_checker.sv
// Port-level checks for the tick timer block, bound to the top level.
// Depends on ttblh_pkg and tick_timers_button_led_haptic_top.
module ttblh_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input ttblh_pkg::out_item_t out_data
);

	// input stalls only when a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// a lit LED always belongs to an engaged button sequence
	a_led_engaged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.led_level |-> out_data.button_active)
		else $error("LED on without engaged button sequence");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind tick_timers_button_led_haptic_top ttblh_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (tick_in.ready),
	.out_valid(result_out.valid),
	.out_ready(result_out.ready),
	.out_data (result_out.data)
);

// File: verif/tick_timers_button_led_haptic_checker.sv
// Checker for the tick timer block: watches tick, result and register channels,
// predicts each tick's levels and compares them with the results in order.
// Depends on ttblh_pkg.
module tick_timers_button_led_haptic_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	input  logic                 tick_ready,
	input  ttblh_pkg::in_item_t  tick_data,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  ttblh_pkg::out_item_t result_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [ttblh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ttblh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                   fails,
	output int                   outstanding
);
	import ttblh_pkg::*;

	localparam int unsigned TW = TIMER_WIDTH;

	logic [PERIOD_W-1:0] sample_period;
	logic [PERIOD_W-1:0] hold_time;
	logic [PERIOD_W-1:0] lit_ticks;
	logic [PERIOD_W-1:0] haptic_half;
	logic [COUNT_W-1:0]  pulse_total;

	logic [TW-1:0]      sample_left;
	logic [TW-1:0]      button_left;
	logic [TW-1:0]      haptic_left;
	logic               button_was;
	logic               button_engaged;
	logic               button_expired_prev;
	logic               led_on;
	logic               haptic_engaged;
	logic               motor_on;
	logic [COUNT_W-1:0] pulse_count;

	out_item_t expected_levels[$];

	function automatic logic [TW-1:0] reload_from(input logic [PERIOD_W-1:0] period);
		return (period == '0) ? '0 : TW'(period - 1'b1);
	endfunction

	task automatic report(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		fails++;
	endtask

	task automatic advance_timers(input in_item_t t, output out_item_t r);
		logic sdue;
		logic bexp;
		logic hdue;
		if (!button_was && t.button_pressed) begin
			button_left = TW'(hold_time);
			button_engaged = 1'b1;
		end
		button_was = t.button_pressed;
		if (!button_expired_prev && !t.button_pressed && !led_on)
			button_engaged = 1'b0;

		if (t.haptic_start) begin
			haptic_left = '0;
			haptic_engaged = 1'b1;
			pulse_count = '0;
			motor_on = 1'b0;
		end

		sdue = (sample_left == '0);
		if (sdue)
			sample_left = reload_from(sample_period);
		else
			sample_left = sample_left - 1'b1;

		bexp = button_engaged && (button_left == '0);
		if (bexp) begin
			if (led_on) begin
				led_on = 1'b0;
				button_engaged = 1'b0;
			end else begin
				led_on = 1'b1;
				button_left = reload_from(lit_ticks);
			end
		end else if (button_engaged && button_left != '0) begin
			button_left = button_left - 1'b1;
		end
		button_expired_prev = bexp;

		hdue = haptic_engaged && (haptic_left == '0);
		if (hdue) begin
			haptic_left = reload_from(haptic_half);
			motor_on = !motor_on;
			if (motor_on) begin
				if (pulse_count < PULSE_COUNT_MAX)
					pulse_count = pulse_count + 1'b1;
			end else if (pulse_count >= pulse_total) begin
				haptic_engaged = 1'b0;
			end
		end else if (haptic_engaged && haptic_left != '0) begin
			haptic_left = haptic_left - 1'b1;
		end

		r.sample_due    = sdue;
		r.button_active = button_engaged;
		r.haptic_due    = hdue;
		r.led_level     = led_on;
		r.motor_level   = motor_on;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			sample_period = SAMPLE_PERIOD_RST;
			hold_time = HOLD_TIME_RST;
			lit_ticks = LIT_TICKS_RST;
			haptic_half = HAPTIC_HALF_RST;
			pulse_total = PULSE_TOTAL_RST;
			sample_left = '0;
			button_left = '0;
			haptic_left = '0;
			button_was = 1'b0;
			button_engaged = 1'b0;
			button_expired_prev = 1'b0;
			led_on = 1'b0;
			haptic_engaged = 1'b0;
			motor_on = 1'b0;
			pulse_count = '0;
			expected_levels.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SAMPLE_PERIOD: sample_period = cfg_data;
					CFG_HOLD_TIME:     hold_time = cfg_data;
					CFG_LIT_TICKS:     lit_ticks = cfg_data;
					CFG_HAPTIC_HALF:   haptic_half = cfg_data;
					CFG_PULSE_TOTAL:   pulse_total = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				got = result_data;
				if (expected_levels.size() == 0) begin
					report($sformatf("result %05b with no tick pending", got));
				end else begin
					want = expected_levels.pop_front();
					if (got.sample_due !== want.sample_due)
						report($sformatf("sample_due %b, want %b", got.sample_due,
							want.sample_due));
					if (got.button_active !== want.button_active)
						report($sformatf("button_active %b, want %b", got.button_active,
							want.button_active));
					if (got.haptic_due !== want.haptic_due)
						report($sformatf("haptic_due %b, want %b", got.haptic_due,
							want.haptic_due));
					if (got.led_level !== want.led_level)
						report($sformatf("led_level %b, want %b", got.led_level,
							want.led_level));
					if (got.motor_level !== want.motor_level)
						report($sformatf("motor_level %b, want %b", got.motor_level,
							want.motor_level));
				end
			end
			if (tick_valid && tick_ready) begin
				advance_timers(tick_data, want);
				expected_levels.push_back(want);
			end
			outstanding <= expected_levels.size();
		end
	end

endmodule

// File: verif/tb.sv
// Testbench top for the tick timer block: clock, reset, tick stimulus under
// several register settings and idle patterns, watchdog and verdict.
// Depends on ttblh_pkg, ttblh_if, the block and its checker.
module tb;
	import ttblh_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;

	logic clk;
	logic arst_n;
	int   fails;
	int   outstanding;
	int   quiet_cycles = 0;

	idle_mode_t          idle_mode;
	logic [PERIOD_W-1:0] hold_w;
	logic [PERIOD_W-1:0] led_w;

	ttblh_in_if  tick_in ();
	ttblh_out_if result_out ();
	ttblh_cfg_if cfg ();

	tick_timers_button_led_haptic_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	tick_timers_button_led_haptic_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_in.valid),
		.tick_ready   (tick_in.ready),
		.tick_data    (tick_in.data),
		.result_valid (result_out.valid),
		.result_ready (result_out.ready),
		.result_data  (result_out.data),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.fails        (fails),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int idle_pct(input idle_mode_t m, input bit sender);
		if (m == IDLE_BOTH)
			return 14;
		if ((sender && m == IDLE_SEND) || (!sender && m == IDLE_RECV))
			return 75;
		return 0;
	endfunction

	initial begin
		result_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_out.ready <= ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b0));
		end
	end

	always @(posedge clk) begin
		if ((tick_in.valid && tick_in.ready) || (result_out.valid && result_out.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tick_timers_button_led_haptic_top test failed");
			$finish;
		end
	end

	task automatic send_tick(input in_item_t item);
		int gap_pct;
		gap_pct = idle_pct(idle_mode, 1'b1);
		while ($urandom_range(0, 99) < gap_pct) begin
			tick_in.valid <= 1'b0;
			@(posedge clk);
		end
		tick_in.valid <= 1'b1;
		tick_in.data <= item;
		@(posedge clk);
		while (!tick_in.ready) @(posedge clk);
	endtask

	// codes: two bits per item {button, start}, first item in the top pair
	task automatic send_pairs(input logic [63:0] codes, input int cnt);
		for (int i = cnt - 1; i >= 0; i--)
			send_tick(in_item_t'(codes[2*i +: 2]));
	endtask

	task automatic drain_results();
		tick_in.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic set_registers(input logic [PERIOD_W-1:0] sp, input logic [PERIOD_W-1:0] ht,
			input logic [PERIOD_W-1:0] lt, input logic [PERIOD_W-1:0] hh,
			input logic [CFG_DATA_W-1:0] pt);
		drain_results();
		write_reg(CFG_SAMPLE_PERIOD, sp);
		write_reg(CFG_HOLD_TIME, ht);
		write_reg(CFG_LIT_TICKS, lt);
		write_reg(CFG_HAPTIC_HALF, hh);
		write_reg(CFG_PULSE_TOTAL, pt);
		cfg.valid <= 1'b0;
		hold_w = ht;
		led_w = lt;
	endtask

	// button held and released in stretches around the hold/LED times, some noise
	task automatic run_ticks(input idle_mode_t m, input int n, input int start_permille);
		int       seg;
		int       span;
		logic     level;
		in_item_t item;
		seg = 0;
		level = 1'b0;
		idle_mode = m;
		for (int i = 0; i < n; i++) begin
			if (seg == 0) begin
				level = ~level;
				span = int'(hold_w) + int'(led_w) + 3;
				if (span > 40)
					span = 40;
				seg = $urandom_range(1, span);
			end
			seg--;
			item.button_pressed = ($urandom_range(0, 99) < 10) ? 1'($urandom_range(0, 1)) : level;
			item.haptic_start = ($urandom_range(0, 999) < start_permille);
			send_tick(item);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		idle_mode = IDLE_NONE;
		tick_in.valid = 1'b0;
		tick_in.data = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		hold_w = HOLD_TIME_RST;
		led_w = LIT_TICKS_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: first tick, press, start, early release
		send_pairs(64'b00_10_11_00_11_10_01, 7);
		// all zero: hold expires at once, timers due every tick, one pulse only
		set_registers('0, '0, '0, '0, '0);
		send_pairs(64'b10_10_10_00_01_00_00_11_00, 9);
		// press while LED lit, then a haptic start
		set_registers(16'd1, 16'd3, 16'd2, 16'd1, 16'd1);
		send_pairs(64'b10_10_10_10_00_10_10_10_11, 9);

		set_registers(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_ticks(IDLE_SEND, 300, 30);
		set_registers('0, '0, '0, '0, '0);
		run_ticks(IDLE_RECV, 200, 50);
		set_registers(16'd3, 16'd5, 16'd4, 16'd2, 16'd3);
		run_ticks(IDLE_BOTH, 150, 20);
		drain_results();
		run_ticks(IDLE_BOTH, 150, 20);

		// long train up to the top pulse count
		set_registers(16'd7, 16'd2, 16'd9, '0, 16'd255);
		idle_mode = IDLE_NONE;
		send_pairs(64'b01, 1);
		run_ticks(IDLE_NONE, 560, 0);

		set_registers('1, '1, '1, '1, '1);
		for (int i = int'(CFG_PULSE_TOTAL) + 1; i < 2**CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
		run_ticks(IDLE_SEND, 100, 30);

		set_registers(16'd2, 16'd3, 16'd6, 16'd1, 16'd2);
		run_ticks(IDLE_RECV, 300, 40);

		repeat (2) begin
			set_registers(PERIOD_W'($urandom_range(0, 12)), PERIOD_W'($urandom_range(0, 12)),
				PERIOD_W'($urandom_range(0, 12)), PERIOD_W'($urandom_range(0, 12)),
				CFG_DATA_W'($urandom_range(0, 12)));
			run_ticks(idle_mode_t'($urandom_range(0, 3)), 100, 40);
		end

		drain_results();
		if (fails == 0)
			$display("tick_timers_button_led_haptic_top test passed");
		else
			$display("tick_timers_button_led_haptic_top test failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/ttblh_pkg.sv
rtl/ttblh_if.sv
rtl/ttblh_core.sv
rtl/ttblh_out_buf.sv
rtl/tick_timers_button_led_haptic_top.sv
rtl/ttblh_checker.sv
verif/tick_timers_button_led_haptic_checker.sv
verif/tb.sv
